FILE: rtl/crbb_pkg.sv
// Shared types and constants of the color region bounding box unit.
package crbb_pkg;

   localparam int CMD_BITS       = 2;
   localparam int BYTE_BITS      = 8;
   localparam int SIZE_REG_BITS  = 13;
   localparam int CSR_INDEX_BITS = 4;
   localparam int EPOCH_BITS     = 4;
   localparam int SCALE_LANES    = 4;
   localparam int DIV_STEPS      = BYTE_BITS;

   localparam logic [CMD_BITS-1:0] CMD_PIXEL = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FRAME = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEIGHT = 4'd1;

   localparam logic [SIZE_REG_BITS-1:0] SIZE_RESET = 13'd256;
   localparam logic [BYTE_BITS-1:0]     SCALE_MAX  = 8'd255;

   typedef enum logic [1:0] {
      OP_PIXEL,
      OP_QUERY,
      OP_FRAME
   } op_kind_type;

   typedef enum logic {
      BACK_CLEAR,
      BACK_RUN
   } back_state_type;

endpackage

FILE: rtl/crbb_channels.sv
// Channel interfaces of the color region bounding box unit.
interface crbb_req_if;
   import crbb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_BITS-1:0]  cmd;
   logic [BYTE_BITS-1:0] red;
   logic [BYTE_BITS-1:0] green;
   modport source (output valid, cmd, red, green, input ready);
   modport sink   (input valid, cmd, red, green, output ready);
endinterface

interface crbb_rsp_if;
   import crbb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [BYTE_BITS-1:0] left_scaled;
   logic [BYTE_BITS-1:0] right_scaled;
   logic [BYTE_BITS-1:0] top_scaled;
   logic [BYTE_BITS-1:0] bottom_scaled;
   modport source (output valid, found, left_scaled, right_scaled, top_scaled, bottom_scaled,
                   input ready);
   modport sink   (input valid, found, left_scaled, right_scaled, top_scaled, bottom_scaled,
                   output ready);
endinterface

interface crbb_csr_if;
   import crbb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [SIZE_REG_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/color_region_bounding_box_unit.sv
// Color region bounding box unit: one transaction per cycle on the request
// channel while the command queue has room. The front part counts pixel
// position and forms the red/green region key; pixel commands then retire one
// per cycle through a two-stage read-modify-write pipeline on the box memory,
// with forwarding of the previous write, so a pixel stream sustains one pixel
// per cycle unless a waiting query or a clearing pass holds the queue. A query
// waits until the scaling unit is free, then passes the box memory read, the
// divider and the response register; the unit produces one quotient bit per
// cycle in four lanes, its last bit waiting for a free response register. New
// frames bump a 4-bit epoch kept in each box entry; after reset and every 15th
// new-frame command a clearing pass rewrites the box memory and holds the queue.
module color_region_bounding_box_unit #(
   parameter int TABLE_SIDE  = 256,
   parameter int COORD_BITS  = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   crbb_req_if.sink    req_ch,
   crbb_rsp_if.source  rsp_ch,
   crbb_csr_if.sink    csr_ch
);

   import crbb_pkg::*;

   localparam int KEY_W = $clog2(TABLE_SIDE * TABLE_SIDE);
   localparam int SZ_W  = COORD_BITS + 1;
   localparam int CMP_W = (SZ_W > SIZE_REG_BITS) ? SZ_W : SIZE_REG_BITS;
   localparam int OP_W  = 2 + KEY_W + 2 * COORD_BITS;
   localparam logic [SZ_W-1:0] SIZE_LIMIT = {1'b1, {COORD_BITS{1'b0}}};

   logic [SIZE_REG_BITS-1:0] width_ff;
   logic [SIZE_REG_BITS-1:0] height_ff;
   logic [SZ_W-1:0]          width_eff;
   logic [SZ_W-1:0]          height_eff;

   logic                     push;
   op_kind_type              push_kind;
   logic [KEY_W-1:0]         push_key;
   logic [COORD_BITS-1:0]    push_col;
   logic [COORD_BITS-1:0]    push_row;
   logic [OP_W-1:0]          queue_wr_data;
   logic [OP_W-1:0]          queue_rd_data;
   logic                     queue_full;
   logic                     queue_empty;
   logic                     pop;

   logic                     scale_idle;
   logic                     query_start;
   logic                     query_found;
   logic [COORD_BITS-1:0]    query_left, query_right, query_top, query_bottom;

   function automatic logic [SZ_W-1:0] eff_size(input logic [SIZE_REG_BITS-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (v == '0) begin
         return SZ_W'(1);
      end
      if (ext > CMP_W'(SIZE_LIMIT)) begin
         return SIZE_LIMIT;
      end
      return SZ_W'(ext);
   endfunction

   assign csr_ch.ready = 1'b1;
   assign width_eff    = eff_size(width_ff);
   assign height_eff   = eff_size(height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_WIDTH:  width_ff  <= csr_ch.data;
            REG_HEIGHT: height_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   crbb_front #(
      .TABLE_SIDE (TABLE_SIDE),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .queue_full (queue_full),
      .push       (push),
      .push_kind  (push_kind),
      .push_key   (push_key),
      .push_col   (push_col),
      .push_row   (push_row)
   );

   assign queue_wr_data = {push_kind, push_key, push_col, push_row};

   crbb_fifo #(
      .WIDTH (OP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (queue_wr_data),
      .pop       (pop),
      .pop_data  (queue_rd_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   crbb_back #(
      .TABLE_SIDE (TABLE_SIDE),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .op_valid     (!queue_empty),
      .op_kind      (op_kind_type'(queue_rd_data[OP_W-1 -: 2])),
      .op_key       (queue_rd_data[2*COORD_BITS +: KEY_W]),
      .op_col       (queue_rd_data[COORD_BITS +: COORD_BITS]),
      .op_row       (queue_rd_data[COORD_BITS-1:0]),
      .pop          (pop),
      .scale_idle   (scale_idle),
      .query_start  (query_start),
      .query_found  (query_found),
      .query_left   (query_left),
      .query_right  (query_right),
      .query_top    (query_top),
      .query_bottom (query_bottom)
   );

   crbb_scale #(
      .COORD_BITS (COORD_BITS)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .start        (query_start),
      .found        (query_found),
      .coord_left   (query_left),
      .coord_right  (query_right),
      .coord_top    (query_top),
      .coord_bottom (query_bottom),
      .width_eff    (width_eff),
      .height_eff   (height_eff),
      .idle         (scale_idle),
      .rsp_ch       (rsp_ch)
   );

endmodule

FILE: rtl/crbb_ram.sv
// Generic simple dual-port RAM with registered read.
module crbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/crbb_fifo.sv
// Short queue between the front and back parts.
module crbb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/crbb_front.sv
// Front part: accepts commands, tracks pixel position and forms region keys.
module crbb_front #(
   parameter int TABLE_SIDE = 256,
   parameter int COORD_BITS = 12,
   localparam int KEY_W = $clog2(TABLE_SIDE * TABLE_SIDE)
) (
   input  logic                   clock,
   input  logic                   reset,
   crbb_req_if.sink               req_ch,
   input  logic [COORD_BITS:0]    width_eff,
   input  logic [COORD_BITS:0]    height_eff,
   input  logic                   queue_full,
   output logic                   push,
   output crbb_pkg::op_kind_type  push_kind,
   output logic [KEY_W-1:0]       push_key,
   output logic [COORD_BITS-1:0]  push_col,
   output logic [COORD_BITS-1:0]  push_row
);

   import crbb_pkg::*;

   localparam int SIDE_BITS  = $clog2(TABLE_SIDE);
   localparam int FOLD_STEPS = $clog2((1 << BYTE_BITS) / TABLE_SIDE) + 1;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  full_ff, full_in;
   logic [COORD_BITS:0]   col_next;
   logic [COORD_BITS:0]   row_next;
   logic [BYTE_BITS-1:0]  red_fold;
   logic [BYTE_BITS-1:0]  green_fold;
   logic                  accept;

   function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] v);
      logic [BYTE_BITS-1:0] r;
      r = v;
      for (int s = FOLD_STEPS - 1; s >= 0; s--) begin
         if (int'(r) >= (TABLE_SIDE << s)) begin
            r = r - BYTE_BITS'(TABLE_SIDE << s);
         end
      end
      return r;
   endfunction

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign red_fold   = fold_byte(req_ch.red);
   assign green_fold = fold_byte(req_ch.green);
   assign push_key   = KEY_W'(green_fold[SIDE_BITS-1:0]) * KEY_W'(TABLE_SIDE)
                     + KEY_W'(red_fold[SIDE_BITS-1:0]);
   assign push_col   = col_ff;
   assign push_row   = row_ff;
   assign col_next   = {1'b0, col_ff} + 1'b1;
   assign row_next   = {1'b0, row_ff} + 1'b1;

   always_comb begin
      push      = 1'b0;
      push_kind = OP_PIXEL;
      col_in    = col_ff;
      row_in    = row_ff;
      full_in   = full_ff;
      if (accept) begin
         unique case (req_ch.cmd)
            CMD_PIXEL: begin
               if (!full_ff && ({1'b0, row_ff} < height_eff)) begin
                  push = 1'b1;
                  if (col_next >= width_eff) begin
                     col_in = '0;
                     if (row_next >= height_eff) begin
                        full_in = 1'b1;
                     end else begin
                        row_in = row_next[COORD_BITS-1:0];
                     end
                  end else begin
                     col_in = col_next[COORD_BITS-1:0];
                  end
               end
            end
            CMD_QUERY: begin
               push      = 1'b1;
               push_kind = OP_QUERY;
            end
            CMD_FRAME: begin
               push      = 1'b1;
               push_kind = OP_FRAME;
               col_in    = '0;
               row_in    = '0;
               full_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         full_ff <= full_in;
      end
   end

endmodule

FILE: rtl/crbb_back.sv
// Back part: box memory read-modify-write, frame epochs and clearing pass.
module crbb_back #(
   parameter int TABLE_SIDE = 256,
   parameter int COORD_BITS = 12,
   localparam int KEY_W = $clog2(TABLE_SIDE * TABLE_SIDE)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  crbb_pkg::op_kind_type  op_kind,
   input  logic [KEY_W-1:0]       op_key,
   input  logic [COORD_BITS-1:0]  op_col,
   input  logic [COORD_BITS-1:0]  op_row,
   output logic                   pop,
   input  logic                   scale_idle,
   output logic                   query_start,
   output logic                   query_found,
   output logic [COORD_BITS-1:0]  query_left,
   output logic [COORD_BITS-1:0]  query_right,
   output logic [COORD_BITS-1:0]  query_top,
   output logic [COORD_BITS-1:0]  query_bottom
);

   import crbb_pkg::*;

   localparam int DEPTH   = TABLE_SIDE * TABLE_SIDE;
   localparam int CB      = COORD_BITS;
   localparam int ENTRY_W = EPOCH_BITS + 4 * CB;

   back_state_type        state_ff, state_in;
   logic [KEY_W-1:0]      clear_addr_ff, clear_addr_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;

   logic                  s1_valid_ff, s1_valid_in;
   op_kind_type           s1_kind_ff;
   logic [KEY_W-1:0]      s1_key_ff;
   logic [CB-1:0]         s1_col_ff;
   logic [CB-1:0]         s1_row_ff;
   logic [EPOCH_BITS-1:0] s1_epoch_ff;

   logic                  fwd_valid_ff, fwd_valid_in;
   logic [KEY_W-1:0]      fwd_key_ff;
   logic [ENTRY_W-1:0]    fwd_entry_ff;

   logic                  issue;
   logic                  pixel_write;
   logic                  ram_wr_en;
   logic [KEY_W-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [ENTRY_W-1:0]    cur_entry;
   logic [ENTRY_W-1:0]    new_entry;
   logic                  seen;
   logic [CB-1:0]         cur_left, cur_right, cur_top, cur_bottom;
   logic [CB-1:0]         new_left, new_right, new_top, new_bottom;

   crbb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (op_key),
      .rd_data (ram_rd_data)
   );

   assign cur_entry  = (fwd_valid_ff && (fwd_key_ff == s1_key_ff)) ? fwd_entry_ff : ram_rd_data;
   assign seen       = (cur_entry[ENTRY_W-1 -: EPOCH_BITS] == s1_epoch_ff);
   assign cur_left   = cur_entry[4*CB-1 -: CB];
   assign cur_right  = cur_entry[3*CB-1 -: CB];
   assign cur_top    = cur_entry[2*CB-1 -: CB];
   assign cur_bottom = cur_entry[CB-1:0];

   assign new_left   = (seen && (cur_left   <= s1_col_ff)) ? cur_left   : s1_col_ff;
   assign new_right  = (seen && (cur_right  >= s1_col_ff)) ? cur_right  : s1_col_ff;
   assign new_top    = (seen && (cur_top    <= s1_row_ff)) ? cur_top    : s1_row_ff;
   assign new_bottom = (seen && (cur_bottom >= s1_row_ff)) ? cur_bottom : s1_row_ff;
   assign new_entry  = {s1_epoch_ff, new_left, new_right, new_top, new_bottom};

   assign pixel_write  = s1_valid_ff && (s1_kind_ff == OP_PIXEL);
   assign query_start  = s1_valid_ff && (s1_kind_ff == OP_QUERY);
   assign query_found  = seen;
   assign query_left   = seen ? cur_left   : '0;
   assign query_right  = seen ? cur_right  : '0;
   assign query_top    = seen ? cur_top    : '0;
   assign query_bottom = seen ? cur_bottom : '0;

   assign issue = (state_ff == BACK_RUN) && op_valid
               && ((op_kind != OP_QUERY) || (scale_idle && !query_start));
   assign pop   = issue;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      epoch_in      = epoch_ff;
      s1_valid_in   = issue && (op_kind != OP_FRAME);
      fwd_valid_in  = pixel_write;
      ram_wr_en     = pixel_write;
      ram_wr_addr   = s1_key_ff;
      ram_wr_data   = new_entry;
      unique case (state_ff)
         BACK_CLEAR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = clear_addr_ff;
            ram_wr_data   = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == KEY_W'(DEPTH - 1)) begin
               state_in = BACK_RUN;
               epoch_in = EPOCH_BITS'(1);
            end
         end
         BACK_RUN: begin
            if (issue && (op_kind == OP_FRAME)) begin
               if (epoch_ff == '1) begin
                  state_in      = BACK_CLEAR;
                  clear_addr_in = '0;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BACK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         epoch_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         clear_addr_ff <= clear_addr_in;
         epoch_ff      <= epoch_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff  <= op_kind;
         s1_key_ff   <= op_key;
         s1_col_ff   <= op_col;
         s1_row_ff   <= op_row;
         s1_epoch_ff <= epoch_ff;
      end
      if (pixel_write) begin
         fwd_key_ff   <= s1_key_ff;
         fwd_entry_ff <= new_entry;
      end
   end

endmodule

FILE: rtl/crbb_scale.sv
// Query scaling: four bit-serial dividers and the response register.
module crbb_scale #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   found,
   input  logic [COORD_BITS-1:0]  coord_left,
   input  logic [COORD_BITS-1:0]  coord_right,
   input  logic [COORD_BITS-1:0]  coord_top,
   input  logic [COORD_BITS-1:0]  coord_bottom,
   input  logic [COORD_BITS:0]    width_eff,
   input  logic [COORD_BITS:0]    height_eff,
   output logic                   idle,
   crbb_rsp_if.source             rsp_ch
);

   import crbb_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam int PROD_W = CB + BYTE_BITS;

   logic                  busy_ff, busy_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  found_ff, found_in;
   logic [CB:0]           rem_ff [SCALE_LANES];
   logic [CB:0]           rem_in [SCALE_LANES];
   logic [BYTE_BITS-1:0]  low_ff [SCALE_LANES];
   logic [BYTE_BITS-1:0]  low_in [SCALE_LANES];
   logic [BYTE_BITS-1:0]  quo_ff [SCALE_LANES];
   logic [BYTE_BITS-1:0]  quo_in [SCALE_LANES];
   logic                  sat_ff [SCALE_LANES];
   logic                  sat_in [SCALE_LANES];

   logic                  out_valid_ff, out_valid_in;
   logic                  out_found_ff, out_found_in;
   logic [BYTE_BITS-1:0]  out_val_ff [SCALE_LANES];
   logic [BYTE_BITS-1:0]  out_val_in [SCALE_LANES];

   logic [CB-1:0]         coord [SCALE_LANES];
   logic [CB:0]           divisor [SCALE_LANES];
   logic [CB+1:0]         trial [SCALE_LANES];
   logic                  take [SCALE_LANES];
   logic [CB:0]           rem_step [SCALE_LANES];
   logic [BYTE_BITS-1:0]  quo_step [SCALE_LANES];
   logic [PROD_W-1:0]     prod [SCALE_LANES];
   logic                  last;
   logic                  slot_free;

   assign coord[0]   = coord_left;
   assign coord[1]   = coord_right;
   assign coord[2]   = coord_top;
   assign coord[3]   = coord_bottom;
   assign divisor[0] = width_eff;
   assign divisor[1] = width_eff;
   assign divisor[2] = height_eff;
   assign divisor[3] = height_eff;

   assign idle      = !busy_ff;
   assign last      = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign slot_free = !out_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.found         = out_found_ff;
   assign rsp_ch.left_scaled   = out_val_ff[0];
   assign rsp_ch.right_scaled  = out_val_ff[1];
   assign rsp_ch.top_scaled    = out_val_ff[2];
   assign rsp_ch.bottom_scaled = out_val_ff[3];

   always_comb begin
      for (int l = 0; l < SCALE_LANES; l++) begin
         trial[l]    = {rem_ff[l], low_ff[l][BYTE_BITS-1]};
         take[l]     = (trial[l] >= {1'b0, divisor[l]});
         rem_step[l] = take[l] ? (CB+1)'(trial[l] - {1'b0, divisor[l]})
                               : trial[l][CB:0];
         quo_step[l] = {quo_ff[l][BYTE_BITS-2:0], take[l]};
         prod[l]     = {coord[l], {BYTE_BITS{1'b0}}} - PROD_W'(coord[l]);
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_found_in = out_found_ff;
      for (int l = 0; l < SCALE_LANES; l++) begin
         rem_in[l]     = rem_ff[l];
         low_in[l]     = low_ff[l];
         quo_in[l]     = quo_ff[l];
         sat_in[l]     = sat_ff[l];
         out_val_in[l] = out_val_ff[l];
      end
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         found_in = found;
         for (int l = 0; l < SCALE_LANES; l++) begin
            sat_in[l] = ({1'b0, coord[l]} >= divisor[l]);
            rem_in[l] = (CB+1)'(prod[l][PROD_W-1:BYTE_BITS]);
            low_in[l] = prod[l][BYTE_BITS-1:0];
            quo_in[l] = '0;
         end
      end else if (busy_ff && (!last || slot_free)) begin
         step_in = step_ff + 1'b1;
         for (int l = 0; l < SCALE_LANES; l++) begin
            rem_in[l] = rem_step[l];
            low_in[l] = {low_ff[l][BYTE_BITS-2:0], 1'b0};
            quo_in[l] = quo_step[l];
         end
         if (last) begin
            busy_in      = 1'b0;
            out_valid_in = 1'b1;
            out_found_in = found_ff;
            for (int l = 0; l < SCALE_LANES; l++) begin
               out_val_in[l] = sat_ff[l] ? SCALE_MAX : quo_step[l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      found_ff     <= found_in;
      out_found_ff <= out_found_in;
      for (int l = 0; l < SCALE_LANES; l++) begin
         rem_ff[l]     <= rem_in[l];
         low_ff[l]     <= low_in[l];
         quo_ff[l]     <= quo_in[l];
         sat_ff[l]     <= sat_in[l];
         out_val_ff[l] <= out_val_in[l];
      end
   end

endmodule

FILE: bench/crbb_region_checker.sv
// Region box predictor and response checker for the color region bounding box unit.
`timescale 1ns / 100ps
module crbb_region_checker #(
   parameter int TABLE_SIDE = 256,
   parameter int COORD_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   crbb_req_if  req_ch,
   crbb_rsp_if  rsp_ch,
   crbb_csr_if  csr_ch,
   output int   error_count,
   output int   pending_count
);

   import crbb_pkg::*;

   localparam int KEY_COUNT  = TABLE_SIDE * TABLE_SIDE;
   localparam int KEY_W      = $clog2(KEY_COUNT);
   localparam int SIZE_LIMIT = 1 << COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [KEY_W-1:0]      key_type;

   typedef struct packed {
      logic                 found;
      logic [BYTE_BITS-1:0] left;
      logic [BYTE_BITS-1:0] right;
      logic [BYTE_BITS-1:0] top;
      logic [BYTE_BITS-1:0] bottom;
   } box_answer_type;

   logic [SIZE_REG_BITS-1:0] width_reg;
   logic [SIZE_REG_BITS-1:0] height_reg;
   bit                       region_seen [KEY_COUNT];
   coord_type                box_left    [KEY_COUNT];
   coord_type                box_right   [KEY_COUNT];
   coord_type                box_top     [KEY_COUNT];
   coord_type                box_bottom  [KEY_COUNT];
   coord_type                column_pos;
   coord_type                row_pos;
   bit                       frame_done;
   box_answer_type           box_answers [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic int unsigned usable_size(input logic [SIZE_REG_BITS-1:0] value);
      if (value == '0) return 1;
      if (32'(value) > SIZE_LIMIT) return SIZE_LIMIT;
      return 32'(value);
   endfunction

   function automatic logic [BYTE_BITS-1:0] scale_to_byte(input coord_type coord,
                                                          input int unsigned divisor);
      int unsigned quotient;
      quotient = (32'(coord) * 32'd255) / divisor;
      return (quotient > 32'(SCALE_MAX)) ? SCALE_MAX : quotient[BYTE_BITS-1:0];
   endfunction

   task automatic clear_frame();
      foreach (region_seen[k]) region_seen[k] = 1'b0;
      column_pos = '0;
      row_pos    = '0;
      frame_done = 1'b0;
   endtask

   task automatic take_pixel(input key_type key);
      int unsigned w;
      int unsigned h;
      w = usable_size(width_reg);
      h = usable_size(height_reg);
      if (frame_done || 32'(row_pos) >= h) return;
      if (!region_seen[key]) begin
         region_seen[key] = 1'b1;
         box_left[key]    = column_pos;
         box_right[key]   = column_pos;
         box_top[key]     = row_pos;
         box_bottom[key]  = row_pos;
      end else begin
         if (column_pos < box_left[key])  box_left[key]   = column_pos;
         if (column_pos > box_right[key]) box_right[key]  = column_pos;
         if (row_pos < box_top[key])      box_top[key]    = row_pos;
         if (row_pos > box_bottom[key])   box_bottom[key] = row_pos;
      end
      if (32'(column_pos) + 32'd1 >= w) begin
         column_pos = '0;
         if (32'(row_pos) + 32'd1 >= h) frame_done = 1'b1;
         else row_pos = row_pos + 1'b1;
      end else begin
         column_pos = column_pos + 1'b1;
      end
   endtask

   function automatic box_answer_type answer_query(input key_type key);
      box_answer_type answer;
      int unsigned    w;
      int unsigned    h;
      answer = '0;
      w = usable_size(width_reg);
      h = usable_size(height_reg);
      if (region_seen[key]) begin
         answer.found  = 1'b1;
         answer.left   = scale_to_byte(box_left[key], w);
         answer.right  = scale_to_byte(box_right[key], w);
         answer.top    = scale_to_byte(box_top[key], h);
         answer.bottom = scale_to_byte(box_bottom[key], h);
      end
      return answer;
   endfunction

   task automatic report(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input logic [BYTE_BITS-1:0] got,
                              input logic [BYTE_BITS-1:0] want);
      if (got !== want)
         report($sformatf("%s mismatch: got %0d expected %0d", field, got, want));
   endtask

   always @(posedge clock) begin
      key_type        key;
      box_answer_type want;
      if (reset) begin
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
         clear_frame();
         box_answers.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == REG_WIDTH) width_reg = csr_ch.data;
            else if (csr_ch.index == REG_HEIGHT) height_reg = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            key = KEY_W'((int'(req_ch.green) % TABLE_SIDE) * TABLE_SIDE
                         + int'(req_ch.red) % TABLE_SIDE);
            case (req_ch.cmd)
               CMD_PIXEL: take_pixel(key);
               CMD_QUERY: box_answers.push_back(answer_query(key));
               CMD_FRAME: clear_frame();
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (box_answers.size() == 0) begin
               report("response with no query waiting");
            end else begin
               want = box_answers.pop_front();
               check_field("found", {7'd0, rsp_ch.found}, {7'd0, want.found});
               check_field("left_scaled", rsp_ch.left_scaled, want.left);
               check_field("right_scaled", rsp_ch.right_scaled, want.right);
               check_field("top_scaled", rsp_ch.top_scaled, want.top);
               check_field("bottom_scaled", rsp_ch.bottom_scaled, want.bottom);
            end
         end
      end
      pending_count = box_answers.size();
   end

endmodule

FILE: bench/tb_top.sv
// Top of the color region bounding box testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
   import crbb_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;
   localparam int ITEM_TARGET   = 800;
   localparam int PALETTE_SIZE  = 8;
   localparam int PAL_W         = $clog2(PALETTE_SIZE);
   localparam int SETTLE_CYCLES = 24;

   logic                 clock;
   logic                 reset;
   int                   error_count;
   int                   pending_count;
   int                   items_sent;
   bit                   steady_source;
   logic [BYTE_BITS-1:0] palette_red   [PALETTE_SIZE];
   logic [BYTE_BITS-1:0] palette_green [PALETTE_SIZE];

   crbb_req_if req_bus ();
   crbb_rsp_if rsp_bus ();
   crbb_csr_if csr_bus ();

   color_region_bounding_box_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   crbb_region_checker box_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_bus),
      .rsp_ch        (rsp_bus),
      .csr_ch        (csr_bus),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_gap(input bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SIZE_REG_BITS-1:0] pick_size();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return SIZE_REG_BITS'(1);
         2: return SIZE_REG_BITS'(4096);
         3: return SIZE_REG_BITS'($urandom_range(4097, 8191));
         4: return SIZE_REG_BITS'(8191);
         5: return SIZE_REG_BITS'($urandom_range(1, 4096));
         default: return SIZE_REG_BITS'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic refresh_palette();
      foreach (palette_red[i]) begin
         palette_red[i]   = ($urandom_range(0, 7) == 0) ? 8'hFF
                                                         : BYTE_BITS'($urandom_range(0, 255));
         palette_green[i] = ($urandom_range(0, 7) == 0) ? 8'h00
                                                         : BYTE_BITS'($urandom_range(0, 255));
      end
   endtask

   task automatic pick_key(output logic [BYTE_BITS-1:0] red, output logic [BYTE_BITS-1:0] green);
      logic [PAL_W-1:0] slot;
      if ($urandom_range(0, 99) < 85) begin
         slot  = PAL_W'($urandom_range(0, PALETTE_SIZE - 1));
         red   = palette_red[slot];
         green = palette_green[slot];
      end else begin
         red   = BYTE_BITS'($urandom_range(0, 255));
         green = BYTE_BITS'($urandom_range(0, 255));
      end
   endtask

   task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [BYTE_BITS-1:0] red,
                            input logic [BYTE_BITS-1:0] green);
      int gap;
      gap = pick_gap(steady_source);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.red   <= red;
      req_bus.green <= green;
      do @(posedge clock); while (!req_bus.ready);
      if (cmd != CMD_SPARE) items_sent++;
   endtask

   task automatic write_size(input logic [SIZE_REG_BITS-1:0] width_value,
                             input logic [SIZE_REG_BITS-1:0] height_value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= REG_WIDTH;
      csr_bus.data  <= width_value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= REG_HEIGHT;
      csr_bus.data  <= height_value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = pick_gap(1'b0);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 8)) @(posedge clock);
      end
   end

   initial begin
      logic [BYTE_BITS-1:0] red;
      logic [BYTE_BITS-1:0] green;
      int                   steps;
      int                   choice;

      items_sent    = 0;
      steady_source = 1'b0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= CMD_PIXEL;
      req_bus.red   <= '0;
      req_bus.green <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_WIDTH;
      csr_bus.data  <= SIZE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fill a 4x2 frame, overrun it, then query seen and unseen keys and send a spare code
      write_size(SIZE_REG_BITS'(4), SIZE_REG_BITS'(2));
      send_item(CMD_FRAME, 8'h00, 8'h00);
      send_item(CMD_PIXEL, 8'h00, 8'h00);
      send_item(CMD_PIXEL, 8'hFF, 8'hFF);
      send_item(CMD_PIXEL, 8'hAA, 8'h55);
      send_item(CMD_PIXEL, 8'h00, 8'h00);
      send_item(CMD_PIXEL, 8'h55, 8'hAA);
      send_item(CMD_PIXEL, 8'hFF, 8'hFF);
      send_item(CMD_PIXEL, 8'h00, 8'h00);
      send_item(CMD_PIXEL, 8'h0F, 8'hF0);
      send_item(CMD_PIXEL, 8'h12, 8'h34);
      send_item(CMD_QUERY, 8'h00, 8'h00);
      send_item(CMD_QUERY, 8'hFF, 8'hFF);
      send_item(CMD_QUERY, 8'h12, 8'h34);
      send_item(CMD_SPARE, 8'h00, 8'h00);
      send_item(CMD_QUERY, 8'h0F, 8'hF0);
      settle();
      // shrink the divisors below the stored coordinates
      write_size(SIZE_REG_BITS'(2), SIZE_REG_BITS'(1));
      send_item(CMD_QUERY, 8'h00, 8'h00);
      settle();
      write_size('0, SIZE_REG_BITS'(8191));
      send_item(CMD_QUERY, 8'hFF, 8'hFF);
      send_item(CMD_FRAME, 8'hFF, 8'hFF);
      send_item(CMD_QUERY, 8'h00, 8'h00);
      settle();

      refresh_palette();
      while (items_sent < ITEM_TARGET) begin
         steady_source = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) refresh_palette();
         write_size(pick_size(), pick_size());
         if ($urandom_range(0, 9) < 7)
            send_item(CMD_FRAME, BYTE_BITS'($urandom_range(0, 255)),
                      BYTE_BITS'($urandom_range(0, 255)));
         steps = $urandom_range(4, 40);
         repeat (steps) begin
            choice = $urandom_range(0, 99);
            pick_key(red, green);
            if (choice < 66) send_item(CMD_PIXEL, red, green);
            else if (choice < 90) send_item(CMD_QUERY, red, green);
            else if (choice < 94) send_item(CMD_FRAME, red, green);
            else send_item(CMD_SPARE, red, green);
         end
         repeat ($urandom_range(1, 3)) begin
            pick_key(red, green);
            send_item(CMD_QUERY, red, green);
         end
         settle();
      end

      steady_source = 1'b0;
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
